FILE: src/assert_macros.svh
// Assertion macros used by the port-level checker in vpcs_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, suppressed during reset.
`define VPCS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, not suppressed by reset.
`define VPCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: src/vpcs_pkg.sv
// Shared types and constants of the video PLL and clamp setup calculator.
`timescale 1ns / 1ps
package vpcs_pkg;

  localparam int SAMP_W = 12;
  localparam int DEN_W  = 12;
  localparam int REFQ_W = 17;  // width of 30 * line_samples

  localparam logic [1:0]  KIND_PC = 2'd0;
  localparam logic [1:0]  KIND_SD = 2'd1;
  localparam logic [1:0]  KIND_ED = 2'd2;
  localparam logic [1:0]  KIND_HD = 2'd3;

  localparam logic [11:0] POSTDIV_LIMIT = 12'd2048;
  localparam logic [4:0]  REF_SCALE     = 5'd30;
  localparam logic [17:0] REF_ROUND     = 18'd5;
  localparam logic [15:0] RECIP10       = 16'd52429;  // 2^19 / 10, rounded up
  localparam int          RECIP10_SH    = 19;

  localparam logic signed [9:0] BASE_HD = 10'sd50;
  localparam logic signed [9:0] BASE_SD = 10'sd6;
  localparam logic signed [9:0] POS_MAX_HD = 10'sd215;
  localparam logic signed [9:0] POS_MAX_SD = 10'sd237;
  localparam logic [5:0]  LEN_HD = 6'd32;
  localparam logic [5:0]  LEN_SD = 6'd16;
  localparam logic [7:0]  ALC_SPAN_HD = 8'd40;  // width plus ALC offset
  localparam logic [7:0]  ALC_SPAN_SD = 8'd18;

  localparam logic [7:0]  SYNC_CTRL_PC    = 8'h0D;
  localparam logic [7:0]  SYNC_CTRL_OTHER = 8'h09;
  localparam logic [2:0]  PUMP_SAT        = 3'd6;

  localparam int PCLK_TH0 = 36000000;   // 36000 kHz times 1000
  localparam int PCLK_TH1 = 70000000;
  localparam int PCLK_TH2 = 135000000;

  // 40 times the VCO gain of each band
  function automatic logic [12:0] pump_num(input logic [1:0] band);
    logic [12:0] v;
    case (band)
      2'd0:    v = 13'd3000;
      2'd1:    v = 13'd3400;
      2'd2:    v = 13'd6000;
      default: v = 13'd8000;
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic              hd;
    logic              pc;
    logic              post;
    logic [12:0]       div_full;
    logic [7:0]        sync_len;
    logic signed [7:0] user;
    logic [11:0]       pixels;
  } ctl_t;

  typedef struct packed {
    ctl_t        ctl;
    logic [11:0] samples;
    logic [11:0] refclk;
  } item_t;

endpackage

FILE: src/vpcs_front.sv
// Front end: accept a mode word, classify it and hand it to the queue.
`timescale 1ns / 1ps
module vpcs_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_video_kind,
  input  logic [11:0]         in_line_samples,
  input  logic [11:0]         in_active_pixels,
  input  logic [11:0]         in_refclk_per_line,
  input  logic                in_want_double_rate,
  input  logic [7:0]          in_sync_len_px,
  input  logic signed [7:0]   in_user_clamp_shift,
  input  logic                q_full,
  output logic                push,
  output vpcs_pkg::item_t     item
);

  logic            vld_r, vld_nxt;
  vpcs_pkg::item_t item_r, item_nxt;
  logic            accept;

  assign busy   = vld_r && q_full;
  assign accept = start && !busy;
  assign push   = vld_r && !q_full;
  assign item   = item_r;
  assign vld_nxt = accept || (vld_r && q_full);

  always_comb begin
    item_nxt.samples = in_line_samples;
    item_nxt.refclk  = (in_refclk_per_line == '0) ? 12'd1 : in_refclk_per_line;
    item_nxt.ctl.pixels = (in_active_pixels == '0) ? 12'd1 : in_active_pixels;
    item_nxt.ctl.hd   = (in_video_kind == vpcs_pkg::KIND_HD);
    item_nxt.ctl.pc   = (in_video_kind == vpcs_pkg::KIND_PC);
    item_nxt.ctl.post = in_want_double_rate && (in_line_samples < vpcs_pkg::POSTDIV_LIMIT);
    item_nxt.ctl.div_full = item_nxt.ctl.post ? {in_line_samples, 1'b0}
                                              : {1'b0, in_line_samples};
    item_nxt.ctl.sync_len = in_sync_len_px;
    item_nxt.ctl.user     = in_user_clamp_shift;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

endmodule

FILE: src/vpcs_fifo.sv
// Two-entry queue between the front end and the back end.
`timescale 1ns / 1ps
module vpcs_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  vpcs_pkg::item_t wr_item,
  output logic            full,
  output logic            rd_valid,
  input  logic            pop,
  output vpcs_pkg::item_t rd_item
);

  vpcs_pkg::item_t mem_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full     = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_item  = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && rd_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

FILE: src/vpcs_div.sv
// Pipelined restoring divider, two dividends over one shared divisor, one bit per stage.
`timescale 1ns / 1ps
module vpcs_div #(
  parameter int NW = 25
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  logic [NW-1:0]               num_a,
  input  logic [NW-1:0]               num_b,
  input  logic [vpcs_pkg::DEN_W-1:0]  den,
  input  vpcs_pkg::ctl_t              tag,
  output logic                        out_vld,
  output logic [NW-1:0]               quo_a,
  output logic [NW-1:0]               quo_b,
  output vpcs_pkg::ctl_t              out_tag
);

  localparam int DW = vpcs_pkg::DEN_W;

  logic           v_r   [NW];
  logic [NW-1:0]  na_r  [NW];
  logic [NW-1:0]  nb_r  [NW];
  logic [NW-1:0]  qa_r  [NW];
  logic [NW-1:0]  qb_r  [NW];
  logic [DW-1:0]  ra_r  [NW];
  logic [DW-1:0]  rb_r  [NW];
  logic [DW-1:0]  den_r [NW];
  vpcs_pkg::ctl_t tag_r [NW];

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic           v_i;
    logic [NW-1:0]  na_i, nb_i, qa_i, qb_i;
    logic [DW-1:0]  ra_i, rb_i, den_i;
    vpcs_pkg::ctl_t tag_i;
    logic [DW:0]    ta, tb;

    if (s == 0) begin : g_first
      assign v_i = in_vld;
      assign na_i = num_a;
      assign nb_i = num_b;
      assign qa_i = '0;
      assign qb_i = '0;
      assign ra_i = '0;
      assign rb_i = '0;
      assign den_i = den;
      assign tag_i = tag;
    end else begin : g_next
      assign v_i = v_r[s-1];
      assign na_i = na_r[s-1];
      assign nb_i = nb_r[s-1];
      assign qa_i = qa_r[s-1];
      assign qb_i = qb_r[s-1];
      assign ra_i = ra_r[s-1];
      assign rb_i = rb_r[s-1];
      assign den_i = den_r[s-1];
      assign tag_i = tag_r[s-1];
    end

    assign ta = {ra_i, na_i[NW-1]};
    assign tb = {rb_i, nb_i[NW-1]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else begin
        v_r[s] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      na_r[s]  <= {na_i[NW-2:0], 1'b0};
      nb_r[s]  <= {nb_i[NW-2:0], 1'b0};
      den_r[s] <= den_i;
      tag_r[s] <= tag_i;
      if (ta >= {1'b0, den_i}) begin
        ra_r[s] <= DW'(ta - {1'b0, den_i});
        qa_r[s] <= {qa_i[NW-2:0], 1'b1};
      end else begin
        ra_r[s] <= ta[DW-1:0];
        qa_r[s] <= {qa_i[NW-2:0], 1'b0};
      end
      if (tb >= {1'b0, den_i}) begin
        rb_r[s] <= DW'(tb - {1'b0, den_i});
        qb_r[s] <= {qb_i[NW-2:0], 1'b1};
      end else begin
        rb_r[s] <= tb[DW-1:0];
        qb_r[s] <= {qb_i[NW-2:0], 1'b0};
      end
    end
  end

  assign out_vld = v_r[NW-1];
  assign quo_a   = qa_r[NW-1];
  assign quo_b   = qb_r[NW-1];
  assign out_tag = tag_r[NW-1];

endmodule

FILE: src/vpcs_back.sv
// Back end: divide, scale, clip and pick the band and pump current.
`timescale 1ns / 1ps
module vpcs_back #(
  parameter int REF_CLOCK_HZ = 27000000
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  vpcs_pkg::item_t q_item,
  output logic            pop,
  output logic            out_valid,
  output logic            out_postdiv_on,
  output logic [11:0]     out_pll_divider,
  output logic [1:0]      out_vco_band,
  output logic [2:0]      out_pump_current,
  output logic [7:0]      out_pll_ctrl_byte,
  output logic [7:0]      out_clamp_start,
  output logic [5:0]      out_clamp_len,
  output logic [7:0]      out_alc_position,
  output logic [7:0]      out_sync_ctrl_byte
);

  localparam int HZ_W = $clog2(REF_CLOCK_HZ + 1);
  localparam int NW   = (HZ_W > vpcs_pkg::REFQ_W) ? HZ_W : vpcs_pkg::REFQ_W;
  localparam int PW   = 13 + NW;
  localparam logic [PW-1:0] TH0 = PW'(vpcs_pkg::PCLK_TH0);
  localparam logic [PW-1:0] TH1 = PW'(vpcs_pkg::PCLK_TH1);
  localparam logic [PW-1:0] TH2 = PW'(vpcs_pkg::PCLK_TH2);

  logic [vpcs_pkg::REFQ_W-1:0] scaled;
  logic                 d_vld;
  logic [NW-1:0]        d_qa, d_qb;
  vpcs_pkg::ctl_t       d_tag;

  assign pop    = q_valid;
  assign scaled = {5'b0, q_item.samples} * {12'b0, vpcs_pkg::REF_SCALE};

  vpcs_div #(.NW(NW)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (q_valid),
    .num_a   (NW'(scaled)),
    .num_b   (NW'(REF_CLOCK_HZ)),
    .den     (q_item.refclk),
    .tag     (q_item.ctl),
    .out_vld (d_vld),
    .quo_a   (d_qa),
    .quo_b   (d_qb),
    .out_tag (d_tag)
  );

  // stage A: reciprocal multiply for the divide by ten, pixel clock product
  logic           a_v_r;
  logic [33:0]    a_rec_r;
  logic [PW-1:0]  a_prod_r;
  vpcs_pkg::ctl_t a_ctl_r;
  logic [17:0]    a_t;

  assign a_t = {1'b0, d_qa[vpcs_pkg::REFQ_W-1:0]} + vpcs_pkg::REF_ROUND;

  always_ff @(posedge clk) begin
    a_rec_r  <= {16'b0, a_t} * {18'b0, vpcs_pkg::RECIP10};
    a_prod_r <= {{NW{1'b0}}, d_tag.div_full} * {13'b0, d_qb};
    a_ctl_r  <= d_tag;
  end

  // stage B: clamp position and VCO band
  logic              b_v_r;
  logic [7:0]        b_pos_r, b_pos_nxt;
  logic [1:0]        b_band_r, b_band_nxt;
  vpcs_pkg::ctl_t    b_ctl_r;
  logic [7:0]        ref_off;
  logic signed [9:0] pos, pos_max;

  always_comb begin
    ref_off = a_ctl_r.sync_len - a_rec_r[vpcs_pkg::RECIP10_SH +: 8];
    pos = $signed({2'b00, ref_off}) + $signed({{2{a_ctl_r.user[7]}}, a_ctl_r.user})
        + (a_ctl_r.hd ? vpcs_pkg::BASE_HD : vpcs_pkg::BASE_SD);
    pos_max = a_ctl_r.hd ? vpcs_pkg::POS_MAX_HD : vpcs_pkg::POS_MAX_SD;
    if (pos < 10'sd0) begin
      b_pos_nxt = 8'd0;
    end else if (pos > pos_max) begin
      b_pos_nxt = pos_max[7:0];
    end else begin
      b_pos_nxt = pos[7:0];
    end
    if (a_prod_r < TH0) begin
      b_band_nxt = 2'd0;
    end else if (a_prod_r < TH1) begin
      b_band_nxt = 2'd1;
    end else if (a_prod_r < TH2) begin
      b_band_nxt = 2'd2;
    end else begin
      b_band_nxt = 2'd3;
    end
  end

  always_ff @(posedge clk) begin
    b_pos_r  <= b_pos_nxt;
    b_band_r <= b_band_nxt;
    b_ctl_r  <= a_ctl_r;
  end

  // stage C: pump current by compare against small multiples, output register
  logic [13:0] pnum;
  logic [2:0]  cp;
  logic        c_v_r;
  logic        c_post_r;
  logic [11:0] c_div_r;
  logic [1:0]  c_band_r;
  logic [2:0]  c_cp_r;
  logic [7:0]  c_pos_r, c_alc_r, c_sync_r;
  logic [5:0]  c_len_r;

  always_comb begin
    pnum = {1'b0, vpcs_pkg::pump_num(b_band_r)} + {3'b0, b_ctl_r.pixels[11:1]};
    cp = 3'd0;
    for (int n = 1; n <= 6; n++) begin
      if ({1'b0, pnum} >= 15'(n) * {3'b0, b_ctl_r.pixels}) begin
        cp = 3'(n);
      end
    end
  end

  always_ff @(posedge clk) begin
    c_post_r <= b_ctl_r.post;
    c_div_r  <= b_ctl_r.div_full[11:0];
    c_band_r <= b_band_r;
    c_cp_r   <= (cp > vpcs_pkg::PUMP_SAT) ? vpcs_pkg::PUMP_SAT : cp;
    c_pos_r  <= b_pos_r;
    c_len_r  <= b_ctl_r.hd ? vpcs_pkg::LEN_HD : vpcs_pkg::LEN_SD;
    c_alc_r  <= b_pos_r + (b_ctl_r.hd ? vpcs_pkg::ALC_SPAN_HD : vpcs_pkg::ALC_SPAN_SD);
    c_sync_r <= b_ctl_r.pc ? vpcs_pkg::SYNC_CTRL_PC : vpcs_pkg::SYNC_CTRL_OTHER;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      a_v_r <= d_vld;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
    end
  end

  assign out_valid          = c_v_r;
  assign out_postdiv_on     = c_post_r;
  assign out_pll_divider    = c_div_r;
  assign out_vco_band       = c_band_r;
  assign out_pump_current   = c_cp_r;
  assign out_pll_ctrl_byte  = {c_band_r, c_cp_r, 3'b000};
  assign out_clamp_start    = c_pos_r;
  assign out_clamp_len      = c_len_r;
  assign out_alc_position   = c_alc_r;
  assign out_sync_ctrl_byte = c_sync_r;

endmodule

FILE: src/video_pll_clamp_setup_calc.sv
// Top level of the video PLL and clamp setup calculator.
`timescale 1ns / 1ps
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  input   | start / busy         | in_video_kind .. in_user_clamp_shift
//  result  | out_valid (strobe)   | out_postdiv_on .. out_sync_ctrl_byte
//
// One mode word is taken per cycle while start is high and busy is low: the front
// end holds the word in one register, a two-entry queue follows, and the back end
// pops whenever the queue holds a word. A word passes the front register, the
// queue, NW divider stages and the three back stages A, B and C before its
// result is strobed, NW = max(17, bits of REF_CLOCK_HZ).
// Reset (rst_n low, synchronous) empties the queue and drops all words in flight.
// busy rises only when the queue is full; the back end never stalls since the
// receiver takes every result in the cycle its strobe is high.
module video_pll_clamp_setup_calc #(
  parameter int REF_CLOCK_HZ = 27000000
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_video_kind,
  input  logic [11:0]       in_line_samples,
  input  logic [11:0]       in_active_pixels,
  input  logic [11:0]       in_refclk_per_line,
  input  logic              in_want_double_rate,
  input  logic [7:0]        in_sync_len_px,
  input  logic signed [7:0] in_user_clamp_shift,
  output logic              out_valid,
  output logic              out_postdiv_on,
  output logic [11:0]       out_pll_divider,
  output logic [1:0]        out_vco_band,
  output logic [2:0]        out_pump_current,
  output logic [7:0]        out_pll_ctrl_byte,
  output logic [7:0]        out_clamp_start,
  output logic [5:0]        out_clamp_len,
  output logic [7:0]        out_alc_position,
  output logic [7:0]        out_sync_ctrl_byte
);

  logic            q_full, push, q_valid, pop;
  vpcs_pkg::item_t f_item, q_item;

  // classify: clamp zero divisors to one, decide post-divide, mark pc / high def
  vpcs_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_video_kind       (in_video_kind),
    .in_line_samples     (in_line_samples),
    .in_active_pixels    (in_active_pixels),
    .in_refclk_per_line  (in_refclk_per_line),
    .in_want_double_rate (in_want_double_rate),
    .in_sync_len_px      (in_sync_len_px),
    .in_user_clamp_shift (in_user_clamp_shift),
    .q_full              (q_full),
    .push                (push),
    .item                (f_item)
  );

  // decouple front and back
  vpcs_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_item  (f_item),
    .full     (q_full),
    .rd_valid (q_valid),
    .pop      (pop),
    .rd_item  (q_item)
  );

  // divide, scale, clip, pick band and pump current
  vpcs_back #(.REF_CLOCK_HZ(REF_CLOCK_HZ)) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_item             (q_item),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_postdiv_on     (out_postdiv_on),
    .out_pll_divider    (out_pll_divider),
    .out_vco_band       (out_vco_band),
    .out_pump_current   (out_pump_current),
    .out_pll_ctrl_byte  (out_pll_ctrl_byte),
    .out_clamp_start    (out_clamp_start),
    .out_clamp_len      (out_clamp_len),
    .out_alc_position   (out_alc_position),
    .out_sync_ctrl_byte (out_sync_ctrl_byte)
  );

endmodule

FILE: src/vpcs_chk.sv
// Port-level checker of the setup calculator, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vpcs_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        busy,
  input logic        out_valid,
  input logic [1:0]  out_vco_band,
  input logic [2:0]  out_pump_current,
  input logic [7:0]  out_pll_ctrl_byte,
  input logic [7:0]  out_clamp_start,
  input logic [5:0]  out_clamp_len,
  input logic [7:0]  out_alc_position,
  input logic [7:0]  out_sync_ctrl_byte
);

  logic [7:0] ctrl_exp, alc_exp;
  logic       is_hd, len_ok;

  assign ctrl_exp = {out_vco_band, out_pump_current, 3'b000};
  assign is_hd    = (out_clamp_len == vpcs_pkg::LEN_HD);
  assign len_ok   = is_hd || (out_clamp_len == vpcs_pkg::LEN_SD);
  assign alc_exp  = out_clamp_start
                  + (is_hd ? vpcs_pkg::ALC_SPAN_HD : vpcs_pkg::ALC_SPAN_SD);

  `VPCS_ASSERT_NEXT(a_reset_quiet, !rst_n, !out_valid && !busy)
  `VPCS_ASSERT_NOW(a_pump_sat, out_valid, out_pump_current <= vpcs_pkg::PUMP_SAT)
  `VPCS_ASSERT_NOW(a_ctrl_byte, out_valid, out_pll_ctrl_byte == ctrl_exp)
  `VPCS_ASSERT_NOW(a_alc_span, out_valid, len_ok && out_alc_position == alc_exp)
  `VPCS_ASSERT_NOW(a_hd_not_pc, out_valid && is_hd, out_sync_ctrl_byte == vpcs_pkg::SYNC_CTRL_OTHER)

endmodule

bind video_pll_clamp_setup_calc vpcs_chk u_vpcs_chk (.*);

FILE: bench/vpcs_checker.sv
// Result checker: predicts each setup word and compares it with the block's output.
`timescale 1ns / 1ps
module vpcs_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [1:0]        in_video_kind,
  input  logic [11:0]       in_line_samples,
  input  logic [11:0]       in_active_pixels,
  input  logic [11:0]       in_refclk_per_line,
  input  logic              in_want_double_rate,
  input  logic [7:0]        in_sync_len_px,
  input  logic signed [7:0] in_user_clamp_shift,
  input  logic              out_valid,
  input  logic              out_postdiv_on,
  input  logic [11:0]       out_pll_divider,
  input  logic [1:0]        out_vco_band,
  input  logic [2:0]        out_pump_current,
  input  logic [7:0]        out_pll_ctrl_byte,
  input  logic [7:0]        out_clamp_start,
  input  logic [5:0]        out_clamp_len,
  input  logic [7:0]        out_alc_position,
  input  logic [7:0]        out_sync_ctrl_byte,
  output int                fail_count,
  output int                pending_count,
  output int                settings_seen
);

  localparam longint REF_HZ = 27000000;

  typedef struct packed {
    logic        postdiv;
    logic [11:0] divider;
    logic [1:0]  band;
    logic [2:0]  pump;
    logic [7:0]  pll_ctrl;
    logic [7:0]  clamp_at;
    logic [5:0]  clamp_w;
    logic [7:0]  alc_pos;
    logic [7:0]  sync_ctrl;
  } setup_t;

  setup_t setup_q[$];

  function automatic setup_t calc_setup(input logic [1:0] kind, input logic [11:0] samp,
                                        input logic [11:0] pix, input logic [11:0] rclk,
                                        input logic dbl, input logic [7:0] slen,
                                        input logic signed [7:0] ushift);
    setup_t s;
    longint rc, px, offs, pos, width, alc_off, base, dv, pclk, gain;
    rc = (rclk == 0) ? 1 : rclk;
    px = (pix == 0) ? 1 : pix;
    offs = (slen - ((30 * samp) / rc + 5) / 10) & 255;
    if (kind == vpcs_pkg::KIND_HD) begin
      base = 50; width = 32; alc_off = 8;
    end else begin
      base = 6; width = 16; alc_off = 2;
    end
    pos = offs + ushift + base;
    if (pos < 0) pos = 0;
    else if (pos + width + alc_off > 255) pos = 255 - alc_off - width;
    s.postdiv = dbl && (samp < 2048);
    dv = s.postdiv ? 2 * samp : samp;
    pclk = (dv * (REF_HZ / rc)) / 1000;
    if (pclk < 36000) s.band = 0;
    else if (pclk < 70000) s.band = 1;
    else if (pclk < 135000) s.band = 2;
    else s.band = 3;
    case (s.band)
      2'd0: gain = 75;
      2'd1: gain = 85;
      2'd2: gain = 150;
      default: gain = 200;
    endcase
    gain = (40 * gain + px / 2) / px;
    s.pump = (gain > 6) ? 3'd6 : gain[2:0];
    s.divider = dv[11:0];
    s.pll_ctrl = {s.band, s.pump, 3'b000};
    s.clamp_at = pos[7:0];
    s.clamp_w = width[5:0];
    s.alc_pos = pos[7:0] + width[7:0] + alc_off[7:0];
    s.sync_ctrl = (kind == vpcs_pkg::KIND_PC) ? vpcs_pkg::SYNC_CTRL_PC
                                              : vpcs_pkg::SYNC_CTRL_OTHER;
    return s;
  endfunction

  task automatic cmp(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    settings_seen = 0;
    pending_count = 0;
  end

  always @(posedge clk) begin
    setup_t e;
    if (rst_n && start && !busy)
      setup_q.push_back(calc_setup(in_video_kind, in_line_samples, in_active_pixels,
                                   in_refclk_per_line, in_want_double_rate,
                                   in_sync_len_px, in_user_clamp_shift));
    if (rst_n && out_valid) begin
      if (setup_q.size() == 0) begin
        $error("result word with no expectation pending");
        fail_count++;
      end else begin
        e = setup_q.pop_front();
        settings_seen++;
        cmp("postdiv_on", e.postdiv, out_postdiv_on);
        cmp("pll_divider", e.divider, out_pll_divider);
        cmp("vco_band", e.band, out_vco_band);
        cmp("pump_current", e.pump, out_pump_current);
        cmp("pll_ctrl_byte", e.pll_ctrl, out_pll_ctrl_byte);
        cmp("clamp_start", e.clamp_at, out_clamp_start);
        cmp("clamp_len", e.clamp_w, out_clamp_len);
        cmp("alc_position", e.alc_pos, out_alc_position);
        cmp("sync_ctrl_byte", e.sync_ctrl, out_sync_ctrl_byte);
      end
    end
    pending_count <= setup_q.size();
  end
endmodule

FILE: bench/tb_video_pll_clamp_setup_calc.sv
// Testbench top: drives mode words into the setup calculator and reports the verdict.
`timescale 1ns / 1ps
module tb_video_pll_clamp_setup_calc;

  // Margin at the end, well beyond the pipeline depth at 27 MHz.
  localparam int DRAIN_CYCLES = 80;
  localparam int N_RANDOM = 1300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_video_kind = '0;
  logic [11:0] in_line_samples = '0;
  logic [11:0] in_active_pixels = '0;
  logic [11:0] in_refclk_per_line = '0;
  logic in_want_double_rate = 1'b0;
  logic [7:0] in_sync_len_px = '0;
  logic signed [7:0] in_user_clamp_shift = '0;
  logic out_valid, out_postdiv_on;
  logic [11:0] out_pll_divider;
  logic [1:0] out_vco_band;
  logic [2:0] out_pump_current;
  logic [7:0] out_pll_ctrl_byte, out_clamp_start, out_alc_position, out_sync_ctrl_byte;
  logic [5:0] out_clamp_len;
  int fail_count, pending_count, settings_seen;
  int words_sent;

  always #4 clk = ~clk;

  video_pll_clamp_setup_calc u_dut (.*);

  vpcs_checker u_chk (.*);

  // Hold one word on the ports until the block takes it; start stays high, so
  // the next call chains straight on, and idle_cycles drops it.
  task automatic send_word(input logic [1:0] kind, input logic [11:0] samp,
                           input logic [11:0] pix, input logic [11:0] rclk,
                           input logic dbl, input logic [7:0] slen,
                           input logic [7:0] ushift);
    start <= 1'b1;
    in_video_kind <= kind;
    in_line_samples <= samp;
    in_active_pixels <= pix;
    in_refclk_per_line <= rclk;
    in_want_double_rate <= dbl;
    in_sync_len_px <= slen;
    in_user_clamp_shift <= ushift;
    do @(posedge clk); while (busy);
    words_sent++;
  endtask

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Pick a 12-bit field, biased toward the edges and realistic line counts.
  function automatic logic [11:0] pick12();
    case ($urandom_range(0, 5))
      0: return 12'($urandom_range(0, 3));
      1: return 12'($urandom_range(4092, 4095));
      2: return 12'($urandom_range(2040, 2056));
      3: return 12'($urandom_range(600, 2500));
      default: return 12'($urandom);
    endcase
  endfunction

  initial begin
    int burst;
    words_sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, every kind, clamp clipping, zero divisors,
    // post-divide boundary and each VCO band.
    send_word(vpcs_pkg::KIND_PC, 12'd1, 12'd1, 12'd1, 1'b0, 8'd0, 8'h80);
    send_word(vpcs_pkg::KIND_HD, 12'd4095, 12'd4095, 12'd4095, 1'b1, 8'd255, 8'h7F);
    send_word(vpcs_pkg::KIND_SD, 12'd0, 12'd0, 12'd0, 1'b1, 8'd10, 8'h00);
    send_word(vpcs_pkg::KIND_ED, 12'd2047, 12'd800, 12'd1716, 1'b1, 8'd64, 8'hF0);
    send_word(vpcs_pkg::KIND_ED, 12'd2048, 12'd800, 12'd1716, 1'b1, 8'd64, 8'h10);
    send_word(vpcs_pkg::KIND_HD, 12'd2200, 12'd1920, 12'd800, 1'b0, 8'd44, 8'h00);
    send_word(vpcs_pkg::KIND_HD, 12'd1650, 12'd1280, 12'd600, 1'b1, 8'd40, 8'hFF);
    send_word(vpcs_pkg::KIND_SD, 12'd858, 12'd720, 12'd1716, 1'b0, 8'd62, 8'h00);
    send_word(vpcs_pkg::KIND_PC, 12'd1344, 12'd1024, 12'd558, 1'b0, 8'd136, 8'h00);
    send_word(vpcs_pkg::KIND_PC, 12'd800, 12'd640, 12'd858, 1'b1, 8'd96, 8'h05);
    send_word(vpcs_pkg::KIND_HD, 12'd100, 12'd3000, 12'd4000, 1'b0, 8'd250, 8'h7F);
    send_word(vpcs_pkg::KIND_SD, 12'd4000, 12'd5, 12'd1, 1'b0, 8'd0, 8'h81);
    send_word(vpcs_pkg::KIND_ED, 12'd1000, 12'd2000, 12'd27, 1'b0, 8'd200, 8'h40);
    send_word(vpcs_pkg::KIND_PC, 12'd3000, 12'd1, 12'd2, 1'b1, 8'd1, 8'hC0);

    // Pause until every expected word is back before the random part.
    idle_cycles(1);
    while (pending_count != 0) @(posedge clk);

    // Random bursts with random gaps; some bursts run back to back.
    while (words_sent < N_RANDOM + 14) begin
      burst = $urandom_range(1, 40);
      repeat (burst)
        send_word(2'($urandom), pick12(), pick12(), pick12(), 1'($urandom),
                  ($urandom_range(0, 3) == 0) ? {7'd0, 1'($urandom)} : 8'($urandom),
                  8'($urandom));
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 12));
    end
    idle_cycles(1);

    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d mode words, %0d setup words checked.", words_sent, settings_seen);
    if (fail_count == 0 && pending_count == 0)
      $display("tb_video_pll_clamp_setup_calc: PASS");
    else
      $display("tb_video_pll_clamp_setup_calc: FAIL");
    $finish;
  end

  // Hard stop if the handshake hangs.
  initial begin
    #2000000;
    $display("tb_video_pll_clamp_setup_calc: FAIL");
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+src
src/vpcs_pkg.sv
src/vpcs_front.sv
src/vpcs_fifo.sv
src/vpcs_div.sv
src/vpcs_back.sv
src/video_pll_clamp_setup_calc.sv
src/vpcs_chk.sv
bench/vpcs_checker.sv
bench/tb_video_pll_clamp_setup_calc.sv
